// ===== sv/bba_pkg.sv =====
// Shared constants, types and codes of the bitmap block allocator.
package bba_pkg;

    localparam int MAX_BLOCKS    = 8192;
    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_WORDS     = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WORD_AW       = $clog2(MAP_WORDS);
    localparam int BIT_W         = $clog2(MAP_WORD_BITS);
    localparam int IDX_W         = 13;
    localparam int CNT_W         = 14;
    localparam int TOTAL_RESET   = 8192;

    typedef logic [MAP_WORD_BITS-1:0] t_word;
    typedef logic [WORD_AW-1:0]       t_waddr;
    typedef logic [BIT_W-1:0]         t_bitpos;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_MARK  = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_kind kind;
        t_idx  block_index;
    } t_req;

    typedef struct packed {
        t_idx    result_index;
        t_status status;
        logic    was_used;
        t_cnt    free_count;
    } t_rsp;

    // Result of one request as the sequencer leaves it, before the free count is added.
    typedef struct packed {
        t_idx    result_index;
        t_status status;
        logic    was_used;
    } t_seq_res;

    // Handshake status from the sequencer to the top level.
    typedef struct packed {
        logic ready;
        logic done;
    } t_seq_stat;

endpackage

// ===== sv/bitmap_block_allocator.sv =====
// Top level of the bitmap block allocator: configuration register, sequencer and output register.
// Free, mark and query go through the fetch, check and done states of the sequencer; allocate
// scans the map, one map word read per cycle, until it finds a clear bit or passes the last word,
// which reports no space. An index out of range, or an allocate with no block managed, goes
// straight to the done state. Every result then moves into the output register, and only then is
// the next request taken. Reset is synchronous and active low; the block count returns to 8192
// and the map is cleared one word a cycle over all 256 words, o_stall held high.
module bitmap_block_allocator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // Request channel.
    input  logic           i_valid,
    output logic           o_stall,
    input  bba_pkg::t_req  i_req,
    // Result channel.
    output logic           o_valid,
    input  logic           i_stall,
    output bba_pkg::t_rsp  o_rsp,
    // Configuration channel: number of managed blocks.
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  bba_pkg::t_cnt  i_cfg_data
);
    import bba_pkg::*;

    t_cnt      r_total;
    logic      r_valid;
    t_rsp      r_rsp;

    t_cnt      limit;
    t_seq_stat seq_stat;
    t_seq_res  seq_res;
    t_cnt      seq_used;
    logic      start;
    logic      take;
    t_cnt      free_cnt;

    // The configuration register is always able to take a beat; the user writes it only
    // while the block is idle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= CNT_W'(TOTAL_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_total <= i_cfg_data;
        end
    end

    // The working limit is the configured block count capped at the size of the map.
    assign limit = (r_total > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : r_total;

    // A request beat is taken only when the sequencer is idle.
    assign o_stall = !seq_stat.ready;
    assign start   = i_valid && seq_stat.ready;

    bba_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .i_limit (limit),
        .i_take  (take),
        .o_stat  (seq_stat),
        .o_res   (seq_res),
        .o_used  (seq_used)
    );

    // The used count may exceed a lowered limit, so the free count saturates at zero.
    assign free_cnt = (limit > seq_used) ? CNT_W'(limit - seq_used) : '0;

    // A finished result moves into the output register whenever that register is empty or
    // its beat is leaving, so the sequencer can start the next request while it waits.
    assign take = seq_stat.done && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
            r_rsp   <= '{result_index: seq_res.result_index, status: seq_res.status,
                         was_used: seq_res.was_used, free_count: free_cnt};
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== sv/bba_bit_scan.sv =====
// First-clear-bit finder over one usage map word, with the tail of the last word masked off.
module bba_bit_scan (
    input  bba_pkg::t_word   i_word,
    input  logic             i_last,
    input  bba_pkg::t_bitpos i_tail,
    output logic             o_found,
    output bba_pkg::t_bitpos o_pos
);
    import bba_pkg::*;

    t_word mask;
    t_word cand;
    t_word v;
    t_bitpos p;

    // Bits at or above the block limit in the last word never count as free.
    always_comb begin
        if (!i_last || (i_tail == '0)) begin
            mask = '1;
        end else begin
            mask = (t_word'(1) << i_tail) - t_word'(1);
        end
        cand = ~i_word & mask;
    end

    // Binary search for the lowest set candidate bit, one halving per level.
    always_comb begin
        v = cand;
        p = '0;
        for (int l = BIT_W - 1; l >= 0; l--) begin
            if ((v & ((t_word'(1) << (1 << l)) - t_word'(1))) == '0) begin
                p[l] = 1'b1;
                v    = v >> (1 << l);
            end
        end
    end

    assign o_found = |cand;
    assign o_pos   = p;

endmodule

// ===== sv/bba_seq.sv =====
// Request sequencer with the usage map memory, its clearing pass and the used block count.
module bba_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  bba_pkg::t_req      i_req,
    input  bba_pkg::t_cnt      i_limit,
    input  logic               i_take,
    output bba_pkg::t_seq_stat o_stat,
    output bba_pkg::t_seq_res  o_res,
    output bba_pkg::t_cnt      o_used
);
    import bba_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_SCAN,
        S_DONE
    } t_state;

    t_state   r_state;
    t_waddr   r_caddr;
    t_req     r_req;
    t_waddr   r_raddr;
    logic     r_issue;
    logic     r_rvalid;
    t_waddr   r_rword;
    t_word    r_rdata;
    t_cnt     r_used;
    t_seq_res r_res;
    t_word    r_map [MAP_WORDS];

    t_cnt    lim_m1;
    t_waddr  lastw;
    t_bitpos tail;
    logic    scan_found;
    t_bitpos scan_pos;
    t_bitpos bit_sel;
    logic    old_bit;
    logic    rd_en;
    logic    wr_en;
    t_waddr  wr_addr;
    t_word   wr_data;

    assign lim_m1  = CNT_W'(i_limit - t_cnt'(1));
    assign lastw   = lim_m1[IDX_W-1:BIT_W];
    assign tail    = i_limit[BIT_W-1:0];
    assign bit_sel = r_req.block_index[BIT_W-1:0];
    assign old_bit = r_rdata[bit_sel];
    assign rd_en   = (r_state == S_FETCH) || ((r_state == S_SCAN) && r_issue);

    bba_bit_scan u_scan (
        .i_word  (r_rdata),
        .i_last  (r_rword == lastw),
        .i_tail  (tail),
        .o_found (scan_found),
        .o_pos   (scan_pos)
    );

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_raddr;
        wr_data = r_rdata;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_caddr;
                wr_data = '0;
            end
            S_CHECK: begin
                if ((r_req.kind == KIND_FREE) && old_bit) begin
                    wr_en   = 1'b1;
                    wr_data = r_rdata & ~(t_word'(1) << bit_sel);
                end else if ((r_req.kind == KIND_MARK) && !old_bit) begin
                    wr_en   = 1'b1;
                    wr_data = r_rdata | (t_word'(1) << bit_sel);
                end
            end
            S_SCAN: begin
                if (r_rvalid && scan_found) begin
                    wr_en   = 1'b1;
                    wr_addr = r_rword;
                    wr_data = r_rdata | (t_word'(1) << scan_pos);
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_map[r_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_caddr  <= '0;
            r_issue  <= 1'b0;
            r_rvalid <= 1'b0;
            r_used   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_caddr <= WORD_AW'(r_caddr + t_waddr'(1));
                    if (r_caddr == WORD_AW'(MAP_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_req <= i_req;
                        if (i_req.kind == KIND_ALLOC) begin
                            if (i_limit == '0) begin
                                r_res   <= '{result_index: '0, status: ST_FULL, was_used: 1'b0};
                                r_state <= S_DONE;
                            end else begin
                                r_raddr  <= '0;
                                r_issue  <= 1'b1;
                                r_rvalid <= 1'b0;
                                r_state  <= S_SCAN;
                            end
                        end else if ({1'b0, i_req.block_index} >= i_limit) begin
                            r_res   <= '{result_index: i_req.block_index, status: ST_RANGE,
                                         was_used: 1'b0};
                            r_state <= S_DONE;
                        end else begin
                            r_raddr <= i_req.block_index[IDX_W-1:BIT_W];
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_res <= '{result_index: r_req.block_index, status: ST_OK,
                               was_used: old_bit};
                    if ((r_req.kind == KIND_FREE) && old_bit) begin
                        r_used <= CNT_W'(r_used - t_cnt'(1));
                    end else if ((r_req.kind == KIND_MARK) && !old_bit) begin
                        r_used <= CNT_W'(r_used + t_cnt'(1));
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    // Words are read ahead one per cycle; the word read in the previous cycle is checked.
                    r_rword <= r_raddr;
                    if (r_rvalid && (scan_found || (r_rword == lastw))) begin
                        if (scan_found) begin
                            r_res  <= '{result_index: IDX_W'({r_rword, scan_pos}),
                                        status: ST_OK, was_used: 1'b0};
                            r_used <= CNT_W'(r_used + t_cnt'(1));
                        end else begin
                            r_res  <= '{result_index: '0, status: ST_FULL, was_used: 1'b0};
                        end
                        r_issue  <= 1'b0;
                        r_rvalid <= 1'b0;
                        r_state  <= S_DONE;
                    end else begin
                        r_rvalid <= rd_en;
                        if (rd_en) begin
                            r_raddr <= WORD_AW'(r_raddr + t_waddr'(1));
                            if (r_raddr == lastw) begin
                                r_issue <= 1'b0;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat = '{ready: (r_state == S_IDLE), done: (r_state == S_DONE)};
    assign o_res  = r_res;
    assign o_used = r_used;

endmodule

// ===== sv/bba_checker.sv =====
// Port-level checker for the bitmap block allocator, bound to the top level.
module bba_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          o_stall,
    input  logic          o_valid,
    input  logic          i_stall,
    input  bba_pkg::t_rsp o_rsp
);
    import bba_pkg::*;

    // A stalled result beat holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("result beat changed while stalled");

    // The clearing pass after reset keeps requests out.
    a_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("request channel open during the clearing pass");

    // Only defined status codes leave the block.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.status == ST_OK) || (o_rsp.status == ST_FULL) ||
                    (o_rsp.status == ST_RANGE))
        else $error("undefined status code");

    // A full map reports index zero and a clear old bit.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.status == ST_FULL) |->
            (o_rsp.result_index == '0) && !o_rsp.was_used)
        else $error("no-space result carries index or old bit");

    // An out-of-range request never reports an old bit.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.status == ST_RANGE) |-> !o_rsp.was_used)
        else $error("out-of-range result carries an old bit");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the bitmap block allocator: directed and random requests.
`timescale 1ns / 1ps

module testbench;

    import bba_pkg::*;

    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 135;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_valid     = 1'b0;
    logic   o_stall;
    t_req   i_req       = '0;
    logic   o_valid;
    logic   i_stall     = 1'b0;
    t_rsp   o_rsp;
    logic   i_cfg_valid = 1'b0;
    logic   o_cfg_ready;
    t_cnt   i_cfg_data  = '0;

    bitmap_block_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the allocator state, updated as each request beat is accepted.
    bit [MAX_BLOCKS-1:0] block_in_use;
    int unsigned         blocks_in_use = 0;
    t_cnt                managed_count = t_cnt'(TOTAL_RESET);

    t_req request_backlog [$];
    t_rsp expected_rsp [$];
    bit   failed      = 1'b0;
    bit   steady_flow = 1'b0;

    // Driver and monitor bookkeeping.
    bit   sending    = 1'b0;
    int   gap_left   = 0;
    int   stall_left = 0;
    t_rsp want_rsp;

    // Idle length for either side: mostly short, now and then long, none in steady phases.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 50) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic int unsigned block_limit();
        return (managed_count > MAX_BLOCKS) ? MAX_BLOCKS : managed_count;
    endfunction

    // Applies one request to the shadow map and returns the result the block should give.
    function automatic t_rsp predict_response(t_req r);
        int unsigned lim;
        int unsigned pos;
        t_rsp        rsp;
        lim = block_limit();
        rsp.result_index = r.block_index;
        rsp.status       = ST_OK;
        rsp.was_used     = 1'b0;
        if (r.kind == KIND_ALLOC) begin
            // First fit: lowest clear bit below the limit.
            pos = 0;
            while (pos < lim && block_in_use[pos]) begin
                pos++;
            end
            if (pos < lim) begin
                block_in_use[pos] = 1'b1;
                blocks_in_use++;
                rsp.result_index = t_idx'(pos);
            end else begin
                rsp.result_index = '0;
                rsp.status       = ST_FULL;
            end
        end else if (r.block_index >= lim) begin
            rsp.status = ST_RANGE;
        end else begin
            rsp.was_used = block_in_use[r.block_index];
            if (r.kind == KIND_FREE && rsp.was_used) begin
                block_in_use[r.block_index] = 1'b0;
                blocks_in_use--;
            end else if (r.kind == KIND_MARK && !rsp.was_used) begin
                block_in_use[r.block_index] = 1'b1;
                blocks_in_use++;
            end
        end
        // Bits above a lowered limit still count as used, so the free count saturates.
        rsp.free_count = t_cnt'((lim > blocks_in_use) ? lim - blocks_in_use : 0);
        return rsp;
    endfunction

    // Request driver: a beat is taken when valid is high and stall is low, then the
    // next request follows after a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sending  = 1'b0;
            gap_left = 0;
        end else begin
            if (sending && !o_stall) begin
                expected_rsp.push_back(predict_response(i_req));
                sending  = 1'b0;
                gap_left = idle_length();
            end
            if (!sending) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_backlog.size() > 0) begin
                    i_req <= request_backlog.pop_front();
                    sending = 1'b1;
                end
            end
        end
        i_valid <= sending;
    end

    // Result monitor: checks every accepted beat against the oldest prediction and
    // stalls the result channel in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_rsp.size() == 0) begin
                    $error("result beat with nothing expected, result_index %0d",
                           o_rsp.result_index);
                    failed = 1'b1;
                end else begin
                    want_rsp = expected_rsp.pop_front();
                    if (o_rsp.result_index !== want_rsp.result_index) begin
                        $error("result_index: expected %0d, got %0d",
                               want_rsp.result_index, o_rsp.result_index);
                        failed = 1'b1;
                    end
                    if (o_rsp.status !== want_rsp.status) begin
                        $error("status: expected %0d, got %0d",
                               want_rsp.status, o_rsp.status);
                        failed = 1'b1;
                    end
                    if (o_rsp.was_used !== want_rsp.was_used) begin
                        $error("was_used: expected %0d, got %0d",
                               want_rsp.was_used, o_rsp.was_used);
                        failed = 1'b1;
                    end
                    if (o_rsp.free_count !== want_rsp.free_count) begin
                        $error("free_count: expected %0d, got %0d",
                               want_rsp.free_count, o_rsp.free_count);
                        failed = 1'b1;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = idle_length();
            end
        end
        i_stall <= (stall_left > 0);
    end

    task automatic queue_req(t_kind k, int unsigned idx);
        t_req r;
        r.kind        = k;
        r.block_index = t_idx'(idx);
        request_backlog.push_back(r);
    endtask

    // Waits until every request has been taken and answered, then lets the block settle.
    task automatic drain();
        do begin
            @(posedge i_clk);
        end while (request_backlog.size() != 0 || i_valid || expected_rsp.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_block_count(t_cnt value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        managed_count  = value;
    endtask

    // Random requests biased towards the managed range so that allocations, frees and
    // marks keep colliding; a few land on the limit or anywhere in the index space.
    task automatic random_phase(int count);
        int unsigned lim;
        int unsigned span;
        int unsigned idx;
        int          r;
        t_kind       k;
        lim  = block_limit();
        span = (lim > 400) ? 400 : lim + lim / 8 + 1;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                k = KIND_ALLOC;
            end else if (r < 65) begin
                k = KIND_FREE;
            end else if (r < 80) begin
                k = KIND_MARK;
            end else begin
                k = KIND_QUERY;
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                idx = $urandom_range(0, MAX_BLOCKS - 1);
            end else if (r == 1) begin
                // Just either side of the limit.
                idx = lim + $urandom_range(0, 3);
                idx = (idx < 2) ? 0 : idx - 2;
            end else begin
                idx = $urandom_range(0, span);
            end
            if (idx > MAX_BLOCKS - 1) begin
                idx = MAX_BLOCKS - 1;
            end
            queue_req(k, idx);
        end
    endtask

    initial begin
        t_cnt phase_totals [0:PHASES-1];
        phase_totals = '{14'd100, 14'd8192, 14'd33, 14'd16383, 14'd1, 14'd64, 14'd0,
                         14'd500, 14'd0};
        phase_totals[PHASES-1] = t_cnt'($urandom_range(1, MAX_BLOCKS));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset limit: first fit, double free, marking a used
        // block and the top index.
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_ALLOC, MAX_BLOCKS - 1);
        queue_req(KIND_QUERY, 0);
        queue_req(KIND_QUERY, 1);
        queue_req(KIND_FREE, 1);
        queue_req(KIND_FREE, 1);
        queue_req(KIND_MARK, 0);
        queue_req(KIND_MARK, MAX_BLOCKS - 1);
        queue_req(KIND_QUERY, MAX_BLOCKS - 1);
        queue_req(KIND_FREE, MAX_BLOCKS - 1);
        queue_req(KIND_QUERY, MAX_BLOCKS - 1);
        queue_req(KIND_MARK, 4096);
        queue_req(KIND_ALLOC, 0);
        drain();

        // Limit lowered below the blocks in use: the free count saturates, indices
        // beyond the limit are refused and allocation runs out of space.
        write_block_count(14'd1);
        queue_req(KIND_QUERY, 1);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_FREE, 0);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_QUERY, MAX_BLOCKS - 1);
        drain();

        // No block managed at all.
        write_block_count(14'd0);
        queue_req(KIND_ALLOC, 0);
        queue_req(KIND_QUERY, 0);
        drain();

        // A limit beyond the map is capped at the map size.
        write_block_count(14'd16383);
        queue_req(KIND_QUERY, 4096);
        queue_req(KIND_FREE, 4096);
        queue_req(KIND_QUERY, MAX_BLOCKS - 1);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            write_block_count(phase_totals[p]);
            steady_flow = ($urandom_range(0, 3) == 0);
            random_phase(PHASE_ITEMS);
            drain();
        end

        if (failed) begin
            $display("FAIL");
        end else begin
            $display("PASS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, including the map clear after reset.
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== bitmap_block_allocator.f =====
sv/bba_pkg.sv
sv/bba_bit_scan.sv
sv/bba_seq.sv
sv/bitmap_block_allocator.sv
sv/bba_checker.sv
sim/testbench.sv
